>>> hw/rtl/wpnr_pkg.sv
package wpnr_pkg;

    // Entries that take part in selection and the bits of each weight that count.
    localparam int ENTRIES     = 5;
    localparam int WEIGHT_BITS = 16;

    // Register file layout: one weight register per entry slot, then the enable mask.
    localparam int NUM_WEIGHTS  = 5;
    localparam int REG_BITS     = 16;
    localparam int MASK_BITS    = 5;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_MASK = 3'd5;

    localparam logic [REG_BITS-1:0] WEIGHT_RESET [NUM_WEIGHTS] =
        '{16'd5000, 16'd3000, 16'd1500, 16'd4000, 16'd1000};
    localparam logic [MASK_BITS-1:0] MASK_RESET = 5'd31;

    // The stored weights are only REG_BITS wide, so at most that many bits count.
    localparam int WEIGHT_USE = (WEIGHT_BITS < REG_BITS) ? WEIGHT_BITS : REG_BITS;
    // Sum of up to five weights needs three extra bits.
    localparam int TOTAL_BITS = WEIGHT_USE + 3;

    localparam int RND_BITS = 32;
    localparam int CNT_BITS = $clog2(RND_BITS);
    localparam int IDX_BITS = 3;
    localparam int ACT_BITS = 3;
    localparam int ST_BITS  = 2;

    localparam logic [IDX_BITS-1:0] NO_PICK = 3'd7;

    // Result status codes.
    localparam logic [ST_BITS-1:0] ST_PICKED = 2'd0;
    localparam logic [ST_BITS-1:0] ST_REPEAT = 2'd1;
    localparam logic [ST_BITS-1:0] ST_NONE   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                start;
        logic                add;
        logic                div;
        logic                scan;
        logic                finish;
        logic [IDX_BITS-1:0] entry;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic total_zero;
        logic out_free;
    } t_status;

endpackage

>>> hw/rtl/wpnr_ctrl.sv
module wpnr_ctrl
    import wpnr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_DIV  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                w_last_entry;

    assign w_last_entry = (r_cnt == CNT_BITS'(ENTRIES - 1));
    assign o_in_ready   = (r_state == S_IDLE);

    // Sequencer: sum the weights, divide one bit a cycle, scan the ranges, deliver.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_cmd.entry = r_cnt[IDX_BITS-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.add = 1'b1;
                if (w_last_entry) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV: begin
                if (i_status.total_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div = 1'b1;
                    if (r_cnt == CNT_BITS'(RND_BITS - 1)) begin
                        n_cnt   = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (w_last_entry) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // The range scan only runs when there is a non-zero total to divide by.
    a_scan_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !i_status.total_zero)
        else $error("range scan entered with a zero weight total");

endmodule

>>> hw/rtl/wpnr_dp.sv
module wpnr_dp
    import wpnr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [REG_BITS-1:0]     i_cfg_data,
    input  logic [RND_BITS-1:0]     i_rnd,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [IDX_BITS-1:0]     o_picked_index,
    output logic [ST_BITS-1:0]      o_pick_status
);

    logic [REG_BITS-1:0]   r_weight [NUM_WEIGHTS];
    logic [MASK_BITS-1:0]  r_mask;
    logic [IDX_BITS-1:0]   r_last;

    logic [RND_BITS-1:0]   r_rnd;
    logic [TOTAL_BITS-1:0] r_total;
    logic [TOTAL_BITS-1:0] r_rem;
    logic [TOTAL_BITS-1:0] r_lower;
    logic [ACT_BITS-1:0]   r_active;
    logic [IDX_BITS-1:0]   r_pick;
    logic                  r_found;

    logic                  r_out_valid;
    logic [IDX_BITS-1:0]   r_out_index;
    logic [ST_BITS-1:0]    r_out_status;

    logic                  w_on;
    logic [REG_BITS-1:0]   w_reg;
    logic [TOTAL_BITS-1:0] w_weight;
    logic [TOTAL_BITS:0]   w_partial;
    logic [TOTAL_BITS:0]   w_diff;
    logic [TOTAL_BITS-1:0] w_upper;
    logic                  w_repeat;
    logic                  w_picked;

    // Selected entry: its enable and its weight, cut to the bits that count.
    assign w_on     = (i_cmd.entry < IDX_BITS'(ENTRIES)) && r_mask[i_cmd.entry];
    assign w_reg    = (i_cmd.entry < IDX_BITS'(NUM_WEIGHTS)) ? r_weight[i_cmd.entry] : '0;
    assign w_weight = TOTAL_BITS'(w_reg[WEIGHT_USE-1:0]);

    // One restoring division step: shift in the next random bit, subtract if it fits.
    assign w_partial = {r_rem, r_rnd[RND_BITS-1]};
    assign w_diff    = w_partial - {1'b0, r_total};

    // Top of the current entry's range.
    assign w_upper = r_lower + w_weight;

    assign w_repeat = (r_pick == r_last) && (r_active > ACT_BITS'(1));
    assign w_picked = i_cmd.finish && !o_status.total_zero && !w_repeat;

    assign o_status.total_zero = (r_total == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                r_weight[i] <= WEIGHT_RESET[i];
            end
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < CFG_IDX_BITS'(NUM_WEIGHTS)) begin
                r_weight[i_cfg_idx] <= i_cfg_data;
            end else if (i_cfg_idx == REG_MASK) begin
                r_mask <= i_cfg_data[MASK_BITS-1:0];
            end
        end
    end

    // Working registers for one request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rnd    <= i_rnd;
            r_total  <= '0;
            r_active <= '0;
            r_rem    <= '0;
            r_lower  <= '0;
            r_pick   <= '0;
            r_found  <= 1'b0;
        end
        if (i_cmd.add && w_on) begin
            r_total  <= r_total + w_weight;
            r_active <= r_active + 1'b1;
        end
        if (i_cmd.div) begin
            r_rnd <= {r_rnd[RND_BITS-2:0], 1'b0};
            if (w_partial >= {1'b0, r_total}) begin
                r_rem <= w_diff[TOTAL_BITS-1:0];
            end else begin
                r_rem <= w_partial[TOTAL_BITS-1:0];
            end
        end
        // The remainder never lies below the running lower bound, so one compare decides.
        if (i_cmd.scan && w_on && !r_found) begin
            if (r_rem < w_upper) begin
                r_pick  <= i_cmd.entry;
                r_found <= 1'b1;
            end else begin
                r_lower <= w_upper;
            end
        end
    end

    // Previous pick and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= NO_PICK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_picked) begin
                r_last <= r_pick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (o_status.total_zero) begin
                r_out_index  <= '0;
                r_out_status <= ST_NONE;
            end else if (w_repeat) begin
                r_out_index  <= '0;
                r_out_status <= ST_REPEAT;
            end else begin
                r_out_index  <= r_pick;
                r_out_status <= ST_PICKED;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_picked_index = r_out_index;
    assign o_pick_status  = r_out_status;

    // The remainder is below the total throughout the range scan.
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_rem < r_total))
        else $error("remainder not below weight total during scan");

    // A non-zero total always yields a pick by the end of the scan.
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !o_status.total_zero) |-> r_found)
        else $error("range scan ended without a pick");

    // A successful pick is both delivered and remembered.
    a_last_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_picked |=> (r_last == $past(r_pick)) && (r_out_index == $past(r_pick))
                     && (r_out_status == ST_PICKED))
        else $error("previous pick not updated with delivered pick");

endmodule

>>> hw/rtl/weighted_pick_no_repeat.sv
// Requests are handled one at a time. The serial remainder takes one quotient bit per
// cycle over the 32-bit random value, plus a five-step sum and scan; the remainder and
// the scan are skipped when the weight total is zero.
// Reset (synchronous, active low) restores the default weights and enable mask and
// clears the previous pick to "no previous pick".
module weighted_pick_no_repeat
    import wpnr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input request
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,   // [31:0] random_value
    // Result
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [2:0] picked_index, [4:3] pick_status
    // Configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [REG_BITS-1:0]     i_cfg_data
);

    t_cmd                w_cmd;
    t_status             w_status;
    logic [IDX_BITS-1:0] w_picked_index;
    logic [ST_BITS-1:0]  w_pick_status;

    // Sequencer.
    wpnr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Registers, arithmetic and result register.
    wpnr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_rnd          (s_axis_tdata),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_picked_index (w_picked_index),
        .o_pick_status  (w_pick_status)
    );

    assign m_axis_tdata = {3'b000, w_pick_status, w_picked_index};

endmodule

>>> tb/tb_weighted_pick_no_repeat.sv
module tb_weighted_pick_no_repeat;
    import wpnr_pkg::*;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_W0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_W1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_W2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_W3 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_W4 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE7 = 3'd7;

    localparam int RANDOM_PICKS = 480;
    localparam int LONG_HOLD    = 300;

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        logic [ST_BITS-1:0]  status;
    } t_pick;

    typedef enum logic {ROW_WRITE, ROW_PICK} t_row_kind;

    // One row of the directed table: a register write or a request, with an
    // optional expected result typed in by hand.
    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_BITS-1:0] reg_idx;
        logic [31:0]             value;
        logic                    typed;
        t_pick                   want;
    } t_dir_row;

    localparam int DIR_ROWS = 29;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // After reset: weights 5000, 3000, 1500, 4000, 1000, all enabled.
        '{ROW_PICK,  REG_W0,     32'd0,          1'b1, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'd0,          1'b1, '{3'd0, ST_REPEAT}},
        '{ROW_PICK,  REG_W0,     32'd14499,      1'b1, '{3'd4, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'd14500,      1'b1, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'hFFFF_FFFF,  1'b0, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'd5000,       1'b0, '{3'd0, ST_PICKED}},
        // Nothing enabled.
        '{ROW_WRITE, REG_MASK,   32'd0,          1'b0, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'hFFFF_FFFF,  1'b1, '{3'd0, ST_NONE}},
        // A single enabled entry may be picked twice in a row.
        '{ROW_WRITE, REG_MASK,   32'd4,          1'b0, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'd123,        1'b1, '{3'd2, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'd456,        1'b1, '{3'd2, ST_PICKED}},
        // Enabled entry of zero weight only: the total is zero.
        '{ROW_WRITE, REG_W2,     32'd0,          1'b0, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'd0,          1'b1, '{3'd0, ST_NONE}},
        // Largest weights everywhere.
        '{ROW_WRITE, REG_W0,     32'hFFFF,       1'b0, '{3'd0, ST_PICKED}},
        '{ROW_WRITE, REG_W1,     32'hFFFF,       1'b0, '{3'd0, ST_PICKED}},
        '{ROW_WRITE, REG_W2,     32'hFFFF,       1'b0, '{3'd0, ST_PICKED}},
        '{ROW_WRITE, REG_W3,     32'hFFFF,       1'b0, '{3'd0, ST_PICKED}},
        '{ROW_WRITE, REG_W4,     32'hFFFF,       1'b0, '{3'd0, ST_PICKED}},
        '{ROW_WRITE, REG_MASK,   32'd31,         1'b0, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'd0,          1'b1, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'hFFFF_FFFF,  1'b0, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'h0001_0000,  1'b0, '{3'd0, ST_PICKED}},
        // Writes to indexes past the register list change nothing.
        '{ROW_WRITE, REG_SPARE6, 32'd0,          1'b0, '{3'd0, ST_PICKED}},
        '{ROW_WRITE, REG_SPARE7, 32'd0,          1'b0, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'd327674,     1'b0, '{3'd0, ST_PICKED}},
        // Enabled zero-weight entry next to one live entry; upper mask bits ignored.
        '{ROW_WRITE, REG_W0,     32'd0,          1'b0, '{3'd0, ST_PICKED}},
        '{ROW_WRITE, REG_MASK,   32'hFFE3,       1'b0, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'd12345,      1'b0, '{3'd0, ST_PICKED}},
        '{ROW_PICK,  REG_W0,     32'd0,          1'b1, '{3'd0, ST_REPEAT}}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [31:0]             s_axis_tdata = '0;    // [31:0] random_value
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [7:0]              m_axis_tdata;         // [2:0] picked_index, [4:3] pick_status
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [REG_BITS-1:0]     i_cfg_data = '0;

    // Own copy of the block's registers and previous pick.
    logic [REG_BITS-1:0]  model_weight [NUM_WEIGHTS];
    logic [MASK_BITS-1:0] model_mask;
    logic [IDX_BITS-1:0]  model_last;

    t_pick owed_picks [$];
    t_pick oldest;
    int    mismatch_count = 0;
    int    random_picks = 0;
    bit    quiet = 1'b0;
    bit    long_hold_req = 1'b0;

    weighted_pick_no_repeat dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Weighted lottery over the enabled entries, with the no-repeat rule.
    function automatic t_pick next_pick(input logic [31:0] rnd);
        logic [31:0]         wmask;
        logic [31:0]         total;
        logic [31:0]         rem;
        logic [31:0]         lower;
        logic [31:0]         w;
        int                  on_cnt;
        int                  i;
        logic [IDX_BITS-1:0] sel;
        logic                found;
        t_pick               res;
        wmask  = (32'd1 << WEIGHT_BITS) - 32'd1;
        total  = '0;
        on_cnt = 0;
        for (i = 0; i < NUM_WEIGHTS; i++) begin
            if (i < ENTRIES && model_mask[i]) begin
                total  += 32'(model_weight[i]) & wmask;
                on_cnt += 1;
            end
        end
        res.idx = '0;
        if (total == 0) begin
            res.status = ST_NONE;
            return res;
        end
        rem   = rnd % total;
        lower = '0;
        sel   = '0;
        found = 1'b0;
        for (i = 0; i < NUM_WEIGHTS; i++) begin
            if (!found && i < ENTRIES && model_mask[i]) begin
                w = 32'(model_weight[i]) & wmask;
                if (rem >= lower && rem - lower < w) begin
                    sel   = IDX_BITS'(i);
                    found = 1'b1;
                end
                lower += w;
            end
        end
        if (sel == model_last && on_cnt > 1) begin
            res.status = ST_REPEAT;
            return res;
        end
        model_last = sel;
        res.idx    = sel;
        res.status = ST_PICKED;
        return res;
    endfunction

    // Offer one request and record what it should produce once it is taken.
    task automatic push_pick(input logic [31:0] rnd, input logic typed, input t_pick want);
        int    gap;
        t_pick p;
        gap = quiet ? 0 : gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rnd;
        do @(posedge i_clk); while (!s_axis_tready);
        p = next_pick(rnd);
        owed_picks.push_back(typed ? want : p);
    endtask

    // Stop offering, then wait until every owed result is back and the block is idle.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (owed_picks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < NUM_WEIGHTS)
            model_weight[idx] = data;
        else if (idx == REG_MASK)
            model_mask = data[MASK_BITS-1:0];
    endtask

    function automatic logic [REG_BITS-1:0] rand_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r < 5)
            return REG_BITS'($urandom_range(1, 20));
        return REG_BITS'($urandom);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        int gap;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                stall_left = LONG_HOLD - 1;
            end else begin
                gap = quiet ? 0 : gap_len();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    stall_left = gap - 1;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Compare every accepted result with the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (owed_picks.size() == 0) begin
                $display("%0t: result with none owed: index %0d status %0d", $time,
                         m_axis_tdata[2:0], m_axis_tdata[4:3]);
                mismatch_count++;
            end else begin
                oldest = owed_picks.pop_front();
                if (m_axis_tdata[2:0] !== oldest.idx) begin
                    $display("%0t: picked_index expected %0d got %0d", $time,
                             oldest.idx, m_axis_tdata[2:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[4:3] !== oldest.status) begin
                    $display("%0t: pick_status expected %0d got %0d", $time,
                             oldest.status, m_axis_tdata[4:3]);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases of settings and requests.
    initial begin
        int    r;
        int    n;
        int    k;
        int    phase;
        t_pick none_typed;
        none_typed = '0;
        for (r = 0; r < NUM_WEIGHTS; r++)
            model_weight[r] = WEIGHT_RESET[r];
        model_mask = MASK_RESET;
        model_last = NO_PICK;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].kind == ROW_WRITE) begin
                settle();
                write_reg(DIR_TABLE[r].reg_idx, DIR_TABLE[r].value[REG_BITS-1:0]);
            end else begin
                push_pick(DIR_TABLE[r].value, DIR_TABLE[r].typed, DIR_TABLE[r].want);
            end
        end

        phase = 0;
        while (random_picks < RANDOM_PICKS) begin
            settle();
            for (k = 0; k < NUM_WEIGHTS; k++)
                if ($urandom_range(0, 2) == 0)
                    write_reg(REG_W0 + CFG_IDX_BITS'(k), rand_weight());
            if ($urandom_range(0, 1) == 0) begin
                n = $urandom_range(0, 19);
                write_reg(REG_MASK, (n == 0) ? REG_BITS'(0) :
                                    (n < 4)  ? REG_BITS'(31) : REG_BITS'($urandom));
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, REG_BITS'($urandom));
            quiet = ($urandom_range(0, 3) == 0);
            // Hold the result side off once while requests keep coming.
            if (phase == 2)
                long_hold_req = 1'b1;
            n = $urandom_range(8, 40);
            for (k = 0; k < n; k++) begin
                push_pick(($urandom_range(0, 9) < 7) ? $urandom : $urandom_range(0, 300),
                          1'b0, none_typed);
                random_picks++;
            end
            phase++;
        end

        settle();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Run limit.
    initial begin
        #(12 * 1000000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/wpnr_pkg.sv
hw/rtl/wpnr_ctrl.sv
hw/rtl/wpnr_dp.sv
hw/rtl/weighted_pick_no_repeat.sv
tb/tb_weighted_pick_no_repeat.sv
